@@ hdl/vqts_pkg.sv @@
`default_nettype none
package vqts_pkg;

  // table geometry
  localparam int TABLE_DEPTH    = 64;
  localparam int IDX_W          = $clog2(TABLE_DEPTH);
  localparam int CNT_W          = IDX_W + 1;

  // test scheduling
  localparam int TESTS_PER_TICK = 8;
  localparam int SLOT_W         = $clog2(TESTS_PER_TICK);
  localparam int PICK_W         = SLOT_W + 1;
  localparam int NUM_BUFFERS    = 2;
  localparam int BUF_W          = $clog2(NUM_BUFFERS);
  localparam int TAG_W          = BUF_W + SLOT_W;

  // field widths
  localparam int KIND_W         = 2;
  localparam int ID_W           = 32;
  localparam int LAT_W          = 7;
  localparam int AGE_W          = 16;
  localparam int FLAG_W         = 6;
  localparam int PRIO_W         = AGE_W + 1;
  localparam int MUF_W          = 8;
  localparam int MUF_RESET      = 10;

  // flag bit positions
  localparam int FL_VIS         = 0;
  localparam int FL_GLASS       = 1;
  localparam int FL_REQ         = 2;
  localparam int FL_PEND        = 3;
  localparam int FL_CTR         = 4;
  localparam int FL_REM         = 5;

  // input word kinds
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESULT = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LAT_W-1:0]  lat;
    logic [AGE_W-1:0]  age;
    logic [FLAG_W-1:0] flags;
  } entry_t;

  // datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_RD,
    OP_NEXT,
    OP_Q_HIT,
    OP_Q_MISS,
    OP_Q_EMIT,
    OP_T_INIT,
    OP_T_EVAL,
    OP_T_WORST,
    OP_I_INIT,
    OP_I_RD,
    OP_I_EMIT,
    OP_RM_INIT,
    OP_RM_CHK,
    OP_RM_MOV,
    OP_R_RD,
    OP_R_FREE,
    OP_R_UPD
  } dp_op_t;

  typedef struct packed {
    logic idx_end;
    logic hit;
    logic replace;
    logic iss_done;
    logic rem;
    logic r_busy;
    logic r_valid;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

@@ hdl/vqts_ctrl.sv @@
`default_nettype none
module vqts_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [vqts_pkg::KIND_W-1:0] in_kind,
  output logic                            in_ready,
  input  wire vqts_pkg::dp_status_t       st,
  output vqts_pkg::dp_op_t                cmd
);
  import vqts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_Q_RD, S_Q_CMP, S_Q_OUT,
    S_T_INIT, S_T_RD, S_T_EVAL, S_T_WORST,
    S_I_INIT, S_I_RD, S_I_OUT,
    S_RM_RD, S_RM_CHK, S_RM_MOV,
    S_R_CHK, S_R_UPD
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and command
  always_comb begin
    state_nxt = state_r;
    cmd       = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = OP_CAPTURE;
          case (in_kind)
            KIND_QUERY:  state_nxt = S_Q_RD;
            KIND_TICK:   state_nxt = S_T_INIT;
            KIND_RESULT: state_nxt = S_R_CHK;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      // query: linear search by id
      S_Q_RD: begin
        if (st.idx_end) begin
          cmd = OP_Q_MISS;  state_nxt = S_Q_OUT;
        end else begin
          cmd = OP_RD;      state_nxt = S_Q_CMP;
        end
      end
      S_Q_CMP: begin
        if (st.hit) begin
          cmd = OP_Q_HIT;   state_nxt = S_Q_OUT;
        end else begin
          cmd = OP_NEXT;    state_nxt = S_Q_RD;
        end
      end
      S_Q_OUT: begin
        if (st.out_free) begin
          cmd = OP_Q_EMIT;  state_nxt = S_IDLE;
        end
      end
      // tick: scan, pick, age, mark stale
      S_T_INIT: begin
        cmd = OP_T_INIT;    state_nxt = S_T_RD;
      end
      S_T_RD: begin
        if (st.idx_end) begin
          state_nxt = S_I_INIT;
        end else begin
          cmd = OP_RD;      state_nxt = S_T_EVAL;
        end
      end
      S_T_EVAL: begin
        cmd       = OP_T_EVAL;
        state_nxt = st.replace ? S_T_WORST : S_T_RD;
      end
      S_T_WORST: begin
        cmd = OP_T_WORST;   state_nxt = S_T_RD;
      end
      // tick: issue tests
      S_I_INIT: begin
        cmd = OP_I_INIT;    state_nxt = S_I_RD;
      end
      S_I_RD: begin
        if (st.iss_done) begin
          cmd = OP_RM_INIT; state_nxt = S_RM_RD;
        end else begin
          cmd = OP_I_RD;    state_nxt = S_I_OUT;
        end
      end
      S_I_OUT: begin
        if (st.out_free) begin
          cmd = OP_I_EMIT;  state_nxt = S_I_RD;
        end
      end
      // tick: swap-remove stale entries
      S_RM_RD: begin
        if (st.idx_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd = OP_RD;      state_nxt = S_RM_CHK;
        end
      end
      S_RM_CHK: begin
        if (st.rem) begin
          cmd = OP_RM_CHK;  state_nxt = S_RM_MOV;
        end else begin
          cmd = OP_NEXT;    state_nxt = S_RM_RD;
        end
      end
      S_RM_MOV: begin
        cmd = OP_RM_MOV;    state_nxt = S_RM_RD;
      end
      // test result
      S_R_CHK: begin
        if (!st.r_busy) begin
          state_nxt = S_IDLE;
        end else if (!st.r_valid) begin
          cmd = OP_R_FREE;  state_nxt = S_IDLE;
        end else begin
          cmd = OP_R_RD;    state_nxt = S_R_UPD;
        end
      end
      S_R_UPD: begin
        cmd = OP_R_UPD;     state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/vqts_dp.sv @@
`default_nettype none
module vqts_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire vqts_pkg::dp_op_t            cmd,
  output vqts_pkg::dp_status_t             st,
  input  wire logic [vqts_pkg::ID_W-1:0]   in_entity_id,
  input  wire logic [vqts_pkg::LAT_W-1:0]  in_latency,
  input  wire logic                        in_ignore_glass,
  input  wire logic                        in_use_center,
  input  wire logic [vqts_pkg::TAG_W-1:0]  in_test_tag,
  input  wire logic                        in_obstructed,
  input  wire logic                        in_all_hits_glass,
  input  wire logic                        in_hit_articulated,
  input  wire logic                        in_hit_owned_by_target,
  input  wire logic                        cfg_we,
  input  wire logic [vqts_pkg::MUF_W-1:0]  cfg_wdata,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic                             out_result_kind,
  output logic                             out_visible,
  output logic [vqts_pkg::ID_W-1:0]        out_target_id,
  output logic [vqts_pkg::IDX_W-1:0]       out_entry_index,
  output logic [vqts_pkg::TAG_W-1:0]       out_issued_tag,
  output logic                             out_check_center,
  output logic                             out_table_full,
  output logic                             out_last
);
  import vqts_pkg::*;

  // entry store, one read and one write port
  entry_t entry_mem_r [TABLE_DEPTH];
  entry_t rd_r;

  // captured input word
  logic [ID_W-1:0]  id_r;
  logic [LAT_W-1:0] lat_r;
  logic             glass_r, ctr_r, obs_r, ahg_r, art_r, own_r;
  logic [TAG_W-1:0] tag_r;

  logic [CNT_W-1:0] idx_r, used_r;
  logic [BUF_W-1:0] tbuf_r;
  logic [MUF_W-1:0] muf_r;

  // pick list
  logic [IDX_W-1:0]         pick_idx_r  [TESTS_PER_TICK];
  logic signed [PRIO_W-1:0] pick_prio_r [TESTS_PER_TICK];
  logic [PICK_W-1:0]        added_r, pj_r, nis_r;
  logic signed [PRIO_W-1:0] worst_r;
  logic [SLOT_W-1:0]        worst_at_r;

  // test receivers
  logic [TESTS_PER_TICK-1:0] rcv_busy_r   [NUM_BUFFERS];
  logic [TESTS_PER_TICK-1:0] rcv_busy_nxt [NUM_BUFFERS];
  logic [IDX_W-1:0]          rcv_idx_r    [NUM_BUFFERS][TESTS_PER_TICK];
  logic [IDX_W-1:0]          rcv_idx_nxt  [NUM_BUFFERS][TESTS_PER_TICK];

  logic hole_pend_r, vis_r, full_r, out_valid_r;

  // derived values
  logic [IDX_W-1:0]         idx_lo, last_idx, iss_e, r_e, rd_addr, wa;
  logic                     rd_en, we, emit, out_free, full_now, cand, stale, pick_full;
  logic                     mov_remap, r_busy;
  logic signed [PRIO_W-1:0] p;
  logic [AGE_W-1:0]         age_inc;
  logic [LAT_W:0]           lat_sum;
  logic [FLAG_W-1:0]        hit_flags, res_flags;
  logic [BUF_W-1:0]         rb;
  logic [SLOT_W-1:0]        rs, iss_slot, w_at;
  logic signed [PRIO_W-1:0] w_max;
  logic [PICK_W-1:0]        free_cnt, n_iss;
  entry_t                   wd;

  assign idx_lo    = idx_r[IDX_W-1:0];
  assign last_idx  = IDX_W'(used_r - CNT_W'(1));
  assign iss_e     = pick_idx_r[pj_r[SLOT_W-1:0]];
  assign rb        = tag_r[SLOT_W +: BUF_W];
  assign rs        = tag_r[SLOT_W-1:0];
  assign r_e       = rcv_idx_r[rb][rs];
  assign r_busy    = rcv_busy_r[rb][rs];
  assign full_now  = (used_r == CNT_W'(TABLE_DEPTH));
  assign emit      = (cmd == OP_Q_EMIT) || (cmd == OP_I_EMIT);
  assign out_free  = !out_valid_r || out_ready;
  assign pick_full = (added_r == PICK_W'(TESTS_PER_TICK));
  assign mov_remap = rd_r.flags[FL_PEND] && (idx_lo != last_idx);

  // entry evaluation during the tick scan
  assign p       = $signed({{(PRIO_W-LAT_W){1'b0}}, rd_r.lat}) - $signed({1'b0, rd_r.age});
  assign cand    = rd_r.flags[FL_REQ] && !rd_r.flags[FL_PEND];
  assign stale   = rd_r.age > (AGE_W'(muf_r) + AGE_W'(rd_r.lat));
  assign age_inc = (&rd_r.age) ? rd_r.age : rd_r.age + AGE_W'(1);

  // query hit update: rounded latency mean
  assign lat_sum = {1'b0, rd_r.lat} + {1'b0, lat_r} + (LAT_W+1)'(1);

  always_comb begin
    hit_flags          = rd_r.flags;
    hit_flags[FL_REQ]  = 1'b1;
    hit_flags[FL_CTR]  = rd_r.flags[FL_CTR] | ctr_r;
  end

  // test outcome decode
  always_comb begin
    res_flags = rd_r.flags;
    res_flags[FL_REQ]  = 1'b0;
    res_flags[FL_PEND] = 1'b0;
    res_flags[FL_CTR]  = 1'b0;
    if (obs_r) begin
      res_flags[FL_VIS]   = art_r && !ahg_r || own_r && !ahg_r && !art_r;
      res_flags[FL_GLASS] = ahg_r || own_r && !art_r;
    end else begin
      res_flags[FL_VIS]   = 1'b1;
      res_flags[FL_GLASS] = 1'b1;
    end
  end

  // new worst after a replacement: maximum, last slot on ties
  always_comb begin
    w_max = worst_r;
    w_at  = worst_at_r;
    for (int j = 0; j < TESTS_PER_TICK; j++) begin
      if (w_max <= pick_prio_r[j]) begin
        w_max = pick_prio_r[j];
        w_at  = SLOT_W'(j);
      end
    end
  end

  // free receivers of the target buffer
  always_comb begin
    free_cnt = '0;
    iss_slot = '0;
    for (int s = TESTS_PER_TICK - 1; s >= 0; s--) begin
      if (!rcv_busy_r[tbuf_r][s]) begin
        free_cnt = free_cnt + PICK_W'(1);
        iss_slot = SLOT_W'(s);
      end
    end
    n_iss = (added_r < free_cnt) ? added_r : free_cnt;
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_lo;
    case (cmd)
      OP_RD:     rd_en = 1'b1;
      OP_I_RD:   begin rd_en = 1'b1; rd_addr = iss_e;    end
      OP_RM_CHK: begin rd_en = 1'b1; rd_addr = last_idx; end
      OP_R_RD:   begin rd_en = 1'b1; rd_addr = r_e;      end
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0;
    wa = idx_lo;
    wd = rd_r;
    case (cmd)
      OP_Q_HIT: begin
        we       = 1'b1;
        wd.lat   = lat_sum[LAT_W:1];
        wd.flags = hit_flags;
      end
      OP_Q_MISS: begin
        we               = !full_now;
        wa               = used_r[IDX_W-1:0];
        wd.id            = id_r;
        wd.lat           = lat_r;
        wd.age           = AGE_W'(lat_r);
        wd.flags         = '0;
        wd.flags[FL_REQ] = 1'b1;
        wd.flags[FL_CTR] = ctr_r;
      end
      OP_T_EVAL: begin
        we     = 1'b1;
        wd.age = age_inc;
        if (!cand && stale) wd.flags[FL_REM] = 1'b1;
      end
      OP_I_EMIT: begin
        we                = 1'b1;
        wa                = iss_e;
        wd.age            = AGE_W'(1);
        wd.flags[FL_PEND] = 1'b1;
        wd.flags[FL_CTR]  = 1'b0;
      end
      OP_RM_MOV: we = 1'b1;
      OP_R_UPD: begin
        we       = 1'b1;
        wa       = r_e;
        wd.flags = res_flags;
        wd.age   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) entry_mem_r[wa] <= wd;
    if (rd_en) rd_r <= entry_mem_r[rd_addr];
  end

  // receiver updates: issue, free, cancel and remap on a move
  always_comb begin
    logic found_c, found_m;
    rcv_busy_nxt = rcv_busy_r;
    rcv_idx_nxt  = rcv_idx_r;
    found_c      = 1'b0;
    found_m      = 1'b0;
    case (cmd)
      OP_I_EMIT: begin
        rcv_busy_nxt[tbuf_r][iss_slot] = 1'b1;
        rcv_idx_nxt[tbuf_r][iss_slot]  = iss_e;
      end
      OP_R_FREE, OP_R_UPD: begin
        rcv_busy_nxt[rb][rs] = 1'b0;
        rcv_idx_nxt[rb][rs]  = '0;
      end
      OP_RM_MOV: begin
        for (int b = 0; b < NUM_BUFFERS; b++) begin
          found_c = 1'b0;
          found_m = 1'b0;
          for (int s = 0; s < TESTS_PER_TICK; s++) begin
            if (hole_pend_r && !found_c && rcv_busy_r[b][s] &&
                rcv_idx_r[b][s] == idx_lo) begin
              rcv_busy_nxt[b][s] = 1'b0;
              rcv_idx_nxt[b][s]  = '0;
              found_c            = 1'b1;
            end
            if (mov_remap && !found_m && rcv_busy_r[b][s] &&
                rcv_idx_r[b][s] == last_idx) begin
              rcv_idx_nxt[b][s] = idx_lo;
              found_m           = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      tbuf_r      <= '0;
      added_r     <= '0;
      idx_r       <= '0;
      pj_r        <= '0;
      nis_r       <= '0;
      out_valid_r <= 1'b0;
      muf_r       <= MUF_W'(MUF_RESET);
      for (int b = 0; b < NUM_BUFFERS; b++) rcv_busy_r[b] <= '0;
    end else begin
      rcv_busy_r <= rcv_busy_nxt;
      if (cfg_we) muf_r <= cfg_wdata;
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      case (cmd)
        OP_CAPTURE: idx_r <= '0;
        OP_NEXT:    idx_r <= idx_r + CNT_W'(1);
        OP_Q_MISS:  if (!full_now) used_r <= used_r + CNT_W'(1);
        OP_T_INIT: begin
          tbuf_r  <= tbuf_r + BUF_W'(1);
          idx_r   <= '0;
          added_r <= '0;
        end
        OP_T_EVAL: begin
          idx_r <= idx_r + CNT_W'(1);
          if (cand && !pick_full) added_r <= added_r + PICK_W'(1);
        end
        OP_I_INIT: begin
          pj_r  <= '0;
          nis_r <= n_iss;
        end
        OP_I_EMIT:  pj_r <= pj_r + PICK_W'(1);
        OP_RM_INIT: idx_r <= '0;
        OP_RM_MOV: begin
          used_r <= used_r - CNT_W'(1);
          idx_r  <= idx_r + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rcv_idx_r <= rcv_idx_nxt;
    case (cmd)
      OP_CAPTURE: begin
        id_r    <= in_entity_id;
        lat_r   <= in_latency;
        glass_r <= in_ignore_glass;
        ctr_r   <= in_use_center;
        tag_r   <= in_test_tag;
        obs_r   <= in_obstructed;
        ahg_r   <= in_all_hits_glass;
        art_r   <= in_hit_articulated;
        own_r   <= in_hit_owned_by_target;
      end
      OP_Q_HIT: begin
        vis_r  <= glass_r ? hit_flags[FL_GLASS] : hit_flags[FL_VIS];
        full_r <= 1'b0;
      end
      OP_Q_MISS: begin
        vis_r  <= 1'b0;
        full_r <= full_now;
      end
      OP_T_EVAL: begin
        if (cand && !pick_full) begin
          pick_idx_r[added_r[SLOT_W-1:0]]  <= idx_lo;
          pick_prio_r[added_r[SLOT_W-1:0]] <= p;
          if (added_r == '0 || p > worst_r) begin
            worst_r    <= p;
            worst_at_r <= added_r[SLOT_W-1:0];
          end
        end else if (cand && p < worst_r) begin
          pick_idx_r[worst_at_r]  <= idx_lo;
          pick_prio_r[worst_at_r] <= p;
          worst_r                 <= p;
        end
      end
      OP_T_WORST: begin
        worst_r    <= w_max;
        worst_at_r <= w_at;
      end
      OP_RM_CHK: hole_pend_r <= rd_r.flags[FL_PEND];
      OP_Q_EMIT: begin
        out_result_kind  <= 1'b0;
        out_visible      <= vis_r;
        out_target_id    <= '0;
        out_entry_index  <= '0;
        out_issued_tag   <= '0;
        out_check_center <= 1'b0;
        out_table_full   <= full_r;
        out_last         <= 1'b1;
      end
      OP_I_EMIT: begin
        out_result_kind  <= 1'b1;
        out_visible      <= 1'b0;
        out_target_id    <= rd_r.id;
        out_entry_index  <= iss_e;
        out_issued_tag   <= {tbuf_r, iss_slot};
        out_check_center <= rd_r.flags[FL_CTR];
        out_table_full   <= 1'b0;
        out_last         <= (pj_r + PICK_W'(1) == nis_r);
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;

  // status to controller
  always_comb begin
    st          = '0;
    st.idx_end  = (idx_r >= used_r);
    st.hit      = (rd_r.id == id_r);
    st.replace  = cand && pick_full && (p < worst_r);
    st.iss_done = (pj_r == nis_r);
    st.rem      = rd_r.flags[FL_REM];
    st.r_busy   = r_busy;
    st.r_valid  = ({1'b0, r_e} < used_r);
    st.out_free = out_free;
  end

  // table never grows past its depth
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // a word is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("output register overwritten");

  // an issued test always finds a free receiver
  a_issue_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == OP_I_EMIT) |-> !(&rcv_busy_r[tbuf_r]))
    else $error("test issued into a full buffer");

  // a swap-remove shrinks the table by one
  a_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == OP_RM_MOV) |=> (used_r == $past(used_r) - CNT_W'(1)))
    else $error("remove did not shrink the table");

endmodule
`default_nettype wire

@@ hdl/visibility_query_table_scheduler_unit.sv @@
// Visibility query table with a per-tick test scheduler.
// Input channel (in_valid/in_ready): one word is a query, a frame tick or a
// test result, selected by in_kind. Result channel (out_valid/out_ready):
// one word per query answer and one per issued test; out_last marks the last
// word caused by an input. A test result and an unknown kind produce nothing.
// cfg_we/cfg_wdata write min_unused_frames; write only when idle.
// Work done for one accepted input word, N entries in use:
//   query : linear search by id; a miss scans all N, appends if not full.
//   tick  : a scan that ages each entry, marks stale ones and fills the pick
//           list, one word per issued test, then a swap-remove pass.
//   result: when its receiver is busy, frees it and updates the entry if valid.
// The entry memory has a registered read; the controller reads or writes
// one entry at a time.
// in_ready is high only while no word is in progress. A finished word waits in
// the output register while the next input is accepted; a stalled receiver
// only stops the block when a second word must be presented.
// Reset (rst_n, synchronous) empties the table, frees all receivers and sets
// min_unused_frames to 10. Table entry contents are not cleared.
`default_nettype none
module visibility_query_table_scheduler_unit (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [vqts_pkg::KIND_W-1:0] in_kind,
  input  wire logic [vqts_pkg::ID_W-1:0]   in_entity_id,
  input  wire logic [vqts_pkg::LAT_W-1:0]  in_latency,
  input  wire logic                        in_ignore_glass,
  input  wire logic                        in_use_center,
  input  wire logic [vqts_pkg::TAG_W-1:0]  in_test_tag,
  input  wire logic                        in_obstructed,
  input  wire logic                        in_all_hits_glass,
  input  wire logic                        in_hit_articulated,
  input  wire logic                        in_hit_owned_by_target,
  input  wire logic                        cfg_we,
  input  wire logic [vqts_pkg::MUF_W-1:0]  cfg_wdata,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_result_kind,
  output logic                             out_visible,
  output logic [vqts_pkg::ID_W-1:0]        out_target_id,
  output logic [vqts_pkg::IDX_W-1:0]       out_entry_index,
  output logic [vqts_pkg::TAG_W-1:0]       out_issued_tag,
  output logic                             out_check_center,
  output logic                             out_table_full,
  output logic                             out_last
);
  import vqts_pkg::*;

  dp_op_t     cmd;
  dp_status_t st;

  vqts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  vqts_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .st                     (st),
    .in_entity_id           (in_entity_id),
    .in_latency             (in_latency),
    .in_ignore_glass        (in_ignore_glass),
    .in_use_center          (in_use_center),
    .in_test_tag            (in_test_tag),
    .in_obstructed          (in_obstructed),
    .in_all_hits_glass      (in_all_hits_glass),
    .in_hit_articulated     (in_hit_articulated),
    .in_hit_owned_by_target (in_hit_owned_by_target),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .out_ready              (out_ready),
    .out_valid              (out_valid),
    .out_result_kind        (out_result_kind),
    .out_visible            (out_visible),
    .out_target_id          (out_target_id),
    .out_entry_index        (out_entry_index),
    .out_issued_tag         (out_issued_tag),
    .out_check_center       (out_check_center),
    .out_table_full         (out_table_full),
    .out_last               (out_last)
  );

endmodule
`default_nettype wire
